// File: rtl/vcfd_pkg.sv
// shared types, constants and the crc-16 byte update for the deframer
package vcfd_pkg;

  localparam int unsigned LEN_W     = 24;
  localparam int unsigned VB_W      = 4;
  localparam int unsigned FLEN_W    = 25;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DW    = 24;

  localparam logic [15:0] CRC_INIT = 16'h1D0F;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 24'hFFFFFF;

  typedef enum logic [2:0] {
    EV_SKIP    = 3'd0,
    EV_HEADER  = 3'd1,
    EV_PAYLOAD = 3'd2,
    EV_CRCLO   = 3'd3,
    EV_GOOD    = 3'd4,
    EV_BAD     = 3'd5,
    EV_LENERR  = 3'd6
  } event_e;

  typedef enum logic [5:0] {
    PH_HUNT    = 6'b000001,
    PH_SECOND  = 6'b000010,
    PH_LEN     = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_CRCLO   = 6'b010000,
    PH_CRCHI   = 6'b100000
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_BYTE   = 1'b0,
    REG_MAX_PAYLOAD = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]       sync_byte;
    logic [LEN_W-1:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    event_e            event_res;
    logic [FLEN_W-1:0] frame_length;
  } res_t;

  // msb first, no reflection, no final xor
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/vcfd_stream_if.sv
// valid/ready stream channel with a typed payload
interface vcfd_stream_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/vcfd_core.sv
// frame state, varint length decode and running crc for one byte per step
module vcfd_core import vcfd_pkg::*; #(
  parameter int unsigned MAX_VARINT_BYTES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  phase_e           phase_q, phase_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [VB_W-1:0]  vb_q, vb_d;
  logic [LEN_W-1:0] left_q, left_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       crc_lo_q, crc_lo_d;

  logic [LEN_W-1:0] part;
  logic             wide;
  logic [LEN_W-1:0] len_new;
  logic [15:0]      crc_upd;

  // seven bits per length byte, anything reaching bit 24 is too wide
  always_comb begin
    part = '0;
    wide = 1'b0;
    unique case (vb_q)
      4'd0:    part = {17'd0, byte_i[6:0]};
      4'd1:    part = {10'd0, byte_i[6:0], 7'd0};
      4'd2:    part = {3'd0, byte_i[6:0], 14'd0};
      4'd3: begin
        part = {byte_i[2:0], 21'd0};
        wide = |byte_i[6:3];
      end
      default: wide = |byte_i[6:0];
    endcase
  end

  assign len_new = len_q | part;
  assign crc_upd = crc16_byte(crc_q, byte_i);

  always_comb begin
    phase_d  = phase_q;
    len_d    = len_q;
    vb_d     = vb_q;
    left_d   = left_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    res_o.out_byte     = byte_i;
    res_o.event_res    = EV_SKIP;
    res_o.frame_length = '0;
    unique case (phase_q)
      PH_HUNT: begin
        if (byte_i == cfg_i.sync_byte) begin
          res_o.event_res = EV_HEADER;
          phase_d         = PH_SECOND;
        end
      end
      PH_SECOND: begin
        res_o.event_res = EV_HEADER;
        len_d   = '0;
        vb_d    = '0;
        left_d  = '0;
        crc_d   = CRC_INIT;
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        crc_d = crc_upd;
        vb_d  = vb_q + 4'd1;
        if (wide) begin
          res_o.event_res = EV_LENERR;
          phase_d         = PH_HUNT;
        end else begin
          len_d = len_new;
          if (!byte_i[7]) begin
            if (len_new > cfg_i.max_payload) begin
              res_o.event_res = EV_LENERR;
              phase_d         = PH_HUNT;
            end else begin
              res_o.event_res = EV_HEADER;
              left_d  = len_new;
              // empty payload goes straight to the crc bytes
              phase_d = (len_new == '0) ? PH_CRCLO : PH_PAYLOAD;
            end
          end else if (vb_d >= VB_W'(MAX_VARINT_BYTES)) begin
            res_o.event_res = EV_LENERR;
            phase_d         = PH_HUNT;
          end else begin
            res_o.event_res = EV_HEADER;
          end
        end
      end
      PH_PAYLOAD: begin
        res_o.event_res = EV_PAYLOAD;
        crc_d  = crc_upd;
        left_d = left_q - 24'd1;
        if (left_d == '0) begin
          phase_d = PH_CRCLO;
        end
      end
      PH_CRCLO: begin
        res_o.event_res = EV_CRCLO;
        crc_lo_d = byte_i;
        phase_d  = PH_CRCHI;
      end
      PH_CRCHI: begin
        if ({byte_i, crc_lo_q} == crc_q) begin
          res_o.event_res    = EV_GOOD;
          res_o.frame_length = FLEN_W'(len_q) + FLEN_W'(vb_q) + 25'd4;
        end else begin
          res_o.event_res = EV_BAD;
        end
        phase_d = PH_HUNT;
      end
      default: phase_d = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      len_q    <= '0;
      vb_q     <= '0;
      left_q   <= '0;
      crc_q    <= CRC_INIT;
      crc_lo_q <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      len_q    <= len_d;
      vb_q     <= vb_d;
      left_q   <= left_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
    end
  end

endmodule

// File: rtl/vcfd_out_stage.sv
// result register driving the output channel
module vcfd_out_stage import vcfd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  res_t  res_i,
  output logic  can_take_o,
  vcfd_stream_if.source out_o
);

  logic valid_q;
  res_t res_q;

  assign can_take_o = !valid_q || out_o.ready;
  assign out_o.valid = valid_q;
  assign out_o.data  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_take_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_take_o && push_i) begin
      res_q <= res_i;
    end
  end

endmodule

// File: rtl/varint_crc16_frame_deframer.sv
// top level: input register, frame decode, result register, config registers
// datapath: a byte is held in the input register, and its result then in the result register
// throughput: one byte per cycle without output stalls, set by the byte-wide crc update and phase decode in one stage
// output stalls hold the result register and back up into the input register
// reset: hunting for sync, sync_byte 0, max_payload 0xFFFFFF, crc 0x1D0F, both stages empty
module varint_crc16_frame_deframer import vcfd_pkg::*; #(
  parameter int unsigned MAX_VARINT_BYTES = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]    cfg_data_i,
  vcfd_stream_if.sink          in_i,
  vcfd_stream_if.source        out_o
);

  cfg_t       cfg_q;
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       can_take;
  logic       step;
  res_t       res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_byte   <= '0;
      cfg_q.max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SYNC_BYTE:   cfg_q.sync_byte   <= cfg_data_i[7:0];
        REG_MAX_PAYLOAD: cfg_q.max_payload <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // byte moves into the result register on this cycle
  assign step       = s1_valid_q && can_take;
  assign in_i.ready = !s1_valid_q || can_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.data;
    end
  end

  vcfd_core #(
    .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (s1_byte_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  vcfd_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s1_valid_q),
    .res_i      (res),
    .can_take_o (can_take),
    .out_o      (out_o)
  );

endmodule
